// ----- hdl/lma_pkg.sv -----
// ----------------------------------------------------------------------------
// Latency metric accumulator package
// Shared constants, command codes and word types of the latency metric unit.
// ----------------------------------------------------------------------------
package lma_pkg;

  // Table sizes.
  localparam int unsigned METRIC_COUNT = 11;
  localparam int unsigned SLOT_COUNT   = 64;

  localparam int unsigned METRIC_AW = (METRIC_COUNT > 1) ? $clog2(METRIC_COUNT) : 1;
  localparam int unsigned SLOT_AW   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // Refill metric register.
  localparam int unsigned CFG_W         = 4;
  localparam logic [CFG_W-1:0] REFILL_ID_RESET = 4'd10;

  typedef enum logic [2:0] {
    CMD_ARM          = 3'd0,
    CMD_BEGIN        = 3'd1,
    CMD_END          = 3'd2,
    CMD_REFILL_BEGIN = 3'd3,
    CMD_REFILL_READY = 3'd4,
    CMD_READ         = 3'd5
  } cmd_e;

  typedef struct packed {
    logic [2:0]  command;
    logic [3:0]  metric_id;
    logic [31:0] start_time;
    logic [15:0] slot;
    logic [31:0] now_cycles;
  } lma_in_t;

  typedef struct packed {
    logic [31:0] timestamp;
    logic        running;
    logic [31:0] calls;
    logic [63:0] total_cycles;
    logic [31:0] peak_cycles;
  } lma_out_t;

  // One entry of the metric table.
  typedef struct packed {
    logic [31:0] calls;
    logic [63:0] total;
    logic [31:0] max;
  } lma_entry_t;

  // Request from the sequencer to the metric unit.
  typedef struct packed {
    logic                 rd;
    logic [METRIC_AW-1:0] addr;
    logic                 add;
    logic [31:0]          sample;
    logic                 clear;
  } lma_metric_req_t;

endpackage

// ----- hdl/latency_metric_accumulator_unit.sv -----
// ----------------------------------------------------------------------------
// Latency metric accumulator
// Gathers latency samples into a table of metrics and refill slots.
// ----------------------------------------------------------------------------
// Usage: a command word enters on in_data_i when in_valid_i is high and
// in_stall_o is low. Every command word yields exactly one result word on
// out_data_o, held while out_stall_i is high. The refill metric register is
// written through cfg_valid_i / cfg_data_i; cfg_ready_o is always high, and
// the register should only be written while the unit is idle.
// Each word is handled in a read step and an update step: on acceptance the
// metric RAM and the slot RAM are read, and in the update step the entry is
// updated, written back and the result is registered. The next word is only
// accepted after the update step, once the unit is idle again. The update
// step waits while an earlier result is still held by a stalled receiver.
// Reset puts the unit in the idle phase with the refill metric at ten. The
// metric table and the slot table carry per-entry valid bits that reset and
// the start of a run clear all together, so no clearing pass is needed and
// the unit accepts words right after reset.
// ----------------------------------------------------------------------------
module latency_metric_accumulator_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  lma_pkg::lma_in_t             in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output lma_pkg::lma_out_t            out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [lma_pkg::CFG_W-1:0]    cfg_data_i
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ARMED,
    PH_RUNNING
  } phase_e;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  logic   out_valid_q, out_valid_d;
  lma_pkg::lma_out_t out_data_q, out_data_d;
  logic [lma_pkg::CFG_W-1:0] cfg_q;
  logic [lma_pkg::SLOT_COUNT-1:0] slot_active_q, slot_active_d;
  lma_pkg::lma_in_t item_q;

  logic accept;
  logic go;
  logic start_now;
  logic in_id_ok, in_slot_ok, in_cfg_ok;
  logic id_ok, slot_ok, cfg_ok;
  lma_pkg::cmd_e cmd;
  lma_pkg::lma_metric_req_t metric_req;
  lma_pkg::lma_entry_t metric_entry;
  logic slot_re, slot_we;
  logic [31:0] slot_rdata;
  logic [lma_pkg::SLOT_AW-1:0] slot_idx;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && (state_q == ST_IDLE);
  // The update step runs once the output register is free or being emptied.
  assign go          = (state_q == ST_EXEC) && (!out_valid_q || !out_stall_i);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Range checks on the incoming word, used to issue the memory reads.
  assign in_id_ok   = (32'(in_data_i.metric_id) < lma_pkg::METRIC_COUNT);
  assign in_slot_ok = (32'(in_data_i.slot) < lma_pkg::SLOT_COUNT);
  assign in_cfg_ok  = (32'(cfg_q) < lma_pkg::METRIC_COUNT);

  // The same checks on the held word for the update step.
  assign id_ok   = (32'(item_q.metric_id) < lma_pkg::METRIC_COUNT);
  assign slot_ok = (32'(item_q.slot) < lma_pkg::SLOT_COUNT);
  assign cfg_ok  = in_cfg_ok;
  assign cmd     = lma_pkg::cmd_e'(item_q.command);
  assign slot_idx = item_q.slot[lma_pkg::SLOT_AW-1:0];

  assign slot_re = accept && in_slot_ok;

  lma_ram #(
    .Width (32),
    .Depth (lma_pkg::SLOT_COUNT)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_idx),
    .wdata_i (item_q.now_cycles),
    .re_i    (slot_re),
    .raddr_i (in_data_i.slot[lma_pkg::SLOT_AW-1:0]),
    .rdata_o (slot_rdata)
  );

  lma_metric_unit u_metric (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (metric_req),
    .entry_o (metric_entry)
  );

  always_comb begin
    state_d       = state_q;
    phase_d       = phase_q;
    out_valid_d   = out_valid_q;
    out_data_d    = out_data_q;
    slot_active_d = slot_active_q;
    slot_we       = 1'b0;
    start_now     = 1'b0;

    // Read side of the metric table, issued with the accepted word.
    metric_req        = '0;
    metric_req.addr   = (in_data_i.command == lma_pkg::CMD_REFILL_READY)
                        ? cfg_q[lma_pkg::METRIC_AW-1:0]
                        : in_data_i.metric_id[lma_pkg::METRIC_AW-1:0];
    metric_req.rd     = accept &&
                        ((((in_data_i.command == lma_pkg::CMD_END) ||
                           (in_data_i.command == lma_pkg::CMD_READ)) && in_id_ok) ||
                         ((in_data_i.command == lma_pkg::CMD_REFILL_READY) && in_cfg_ok));

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (accept) begin
      state_d = ST_EXEC;
    end

    if (go) begin
      state_d     = ST_IDLE;
      out_valid_d = 1'b1;
      out_data_d  = '0;
      unique case (cmd)
        lma_pkg::CMD_ARM: begin
          phase_d = PH_ARMED;
        end
        lma_pkg::CMD_BEGIN: begin
          start_now = (phase_q == PH_ARMED);
          out_data_d.timestamp = item_q.now_cycles;
        end
        lma_pkg::CMD_END: begin
          if ((phase_q == PH_RUNNING) && id_ok) begin
            metric_req.add    = 1'b1;
            metric_req.sample = item_q.now_cycles - item_q.start_time;
          end
        end
        lma_pkg::CMD_REFILL_BEGIN: begin
          start_now = (phase_q == PH_ARMED);
          out_data_d.timestamp = item_q.now_cycles;
        end
        lma_pkg::CMD_REFILL_READY: begin
          if ((phase_q == PH_RUNNING) && slot_ok && slot_active_q[slot_idx]) begin
            metric_req.add    = cfg_ok;
            metric_req.sample = item_q.now_cycles - slot_rdata;
            slot_active_d[slot_idx] = 1'b0;
          end
        end
        lma_pkg::CMD_READ: begin
          if (id_ok) begin
            out_data_d.calls        = metric_entry.calls;
            out_data_d.total_cycles = metric_entry.total;
            out_data_d.peak_cycles  = metric_entry.max;
          end
        end
        default: begin
        end
      endcase

      // Starting a run wipes the metric table and every slot.
      if (start_now) begin
        phase_d          = PH_RUNNING;
        metric_req.clear = 1'b1;
        slot_active_d    = '0;
      end

      // A refill begin stamps its slot once the phase is running.
      if ((cmd == lma_pkg::CMD_REFILL_BEGIN) && (phase_d == PH_RUNNING) && slot_ok) begin
        slot_we                 = 1'b1;
        slot_active_d[slot_idx] = 1'b1;
      end

      out_data_d.running = (phase_d == PH_RUNNING);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      phase_q       <= PH_IDLE;
      out_valid_q   <= 1'b0;
      out_data_q    <= '0;
      cfg_q         <= lma_pkg::REFILL_ID_RESET;
      slot_active_q <= '0;
    end else begin
      state_q       <= state_d;
      phase_q       <= phase_d;
      out_valid_q   <= out_valid_d;
      out_data_q    <= out_data_d;
      slot_active_q <= slot_active_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
    end
  end

  // The update step never waits when the output register is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC) && !out_valid_q |=> out_valid_q && (state_q == ST_IDLE))
    else $error("update step did not complete with a free output register");

  // The running flag of a result reflects the phase left by its word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    go |=> (out_data_q.running == (phase_q == PH_RUNNING)))
    else $error("running flag disagrees with the phase");

  // Starting a run leaves no refill slot active, apart from the slot stamped by a refill begin that starts it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    go && start_now |=> (slot_active_q == '0) || (slot_active_q == $past(slot_active_d)))
    else $error("slot table not cleared at the start of a run");

  // Only a read command returns metric contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    go && (cmd != lma_pkg::CMD_READ) |=>
      (out_data_q.calls == '0) && (out_data_q.total_cycles == '0) &&
      (out_data_q.peak_cycles == '0))
    else $error("metric contents on a result of a non-read command");

endmodule

// ----- hdl/lma_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module lma_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64,
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/lma_metric_unit.sv -----
// ----------------------------------------------------------------------------
// Metric table
// Holds calls, total and maximum of each metric in a RAM with one valid bit
// per entry, and applies one sample as a read-modify-write.
// ----------------------------------------------------------------------------
module lma_metric_unit (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  lma_pkg::lma_metric_req_t req_i,
  output lma_pkg::lma_entry_t      entry_o
);

  logic [lma_pkg::METRIC_COUNT-1:0] valid_q, valid_d;
  logic [lma_pkg::METRIC_AW-1:0]    addr_q;
  logic [$bits(lma_pkg::lma_entry_t)-1:0] ram_rdata;
  lma_pkg::lma_entry_t cur_entry, upd_entry;

  lma_ram #(
    .Width ($bits(lma_pkg::lma_entry_t)),
    .Depth (lma_pkg::METRIC_COUNT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (req_i.add),
    .waddr_i (addr_q),
    .wdata_i (upd_entry),
    .re_i    (req_i.rd),
    .raddr_i (req_i.addr),
    .rdata_o (ram_rdata)
  );

  // An entry that has not been written since the last clear reads as zero.
  assign cur_entry = valid_q[addr_q] ? lma_pkg::lma_entry_t'(ram_rdata) : '0;
  assign entry_o   = cur_entry;

  always_comb begin
    upd_entry       = cur_entry;
    upd_entry.calls = cur_entry.calls + 32'd1;
    upd_entry.total = cur_entry.total + {32'd0, req_i.sample};
    if (req_i.sample > cur_entry.max) begin
      upd_entry.max = req_i.sample;
    end
    valid_d = valid_q;
    if (req_i.clear) begin
      valid_d = '0;
    end else if (req_i.add) begin
      valid_d[addr_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd) begin
      addr_q <= req_i.addr;
    end
  end

endmodule
